// ----- sv/brs_pkg.sv -----
// brs_pkg: constants, codes and types shared by the bilinear resampler
// used by brs_div and bilinear_gray_resampler; depends on nothing else
package brs_pkg;

  // image and coordinate geometry
  localparam int MAX_DIM   = 256;
  localparam int COORD_W   = $clog2(MAX_DIM);       // pixel index bits
  localparam int DIM_W     = COORD_W + 1;           // size register bits
  localparam int ADDR_W    = 2 * COORD_W;           // image store address bits
  localparam int PIX_W     = 8;

  // fixed point
  localparam int FRAC_BITS = 16;
  localparam int W_W       = FRAC_BITS + 1;         // weight 0..1 inclusive
  localparam int PROD_W    = 2 * DIM_W - 1;         // (2o+1)*s fits here
  localparam int DVD_W     = PROD_W + FRAC_BITS - 1;
  localparam int DIV_STEPS = DVD_W / 2;             // two quotient bits a step
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [DVD_W-1:0] HALF_POS = DVD_W'(1) << (FRAC_BITS - 1);
  localparam logic [W_W-1:0]   W_ONE    = W_W'(1) << FRAC_BITS;

  // operation codes carried in tuser
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // register indexes
  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_OUT_W = 2'd2;
  localparam logic [1:0] REG_OUT_H = 2'd3;

  // clamped neighbour indexes and weight along one axis
  typedef struct packed {
    logic [COORD_W-1:0] i0;
    logic [COORD_W-1:0] i1;
    logic [W_W-1:0]     w;
  } axis_t;

endpackage

// ----- sv/brs_div.sv -----
// brs_div: radix-4 restoring divider for the source position quotient
// depends on brs_pkg; one start pulse, done pulses when the quotient is ready
module brs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [brs_pkg::DVD_W-1:0]   dividend_i,
  input  logic [brs_pkg::DIM_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [brs_pkg::DVD_W-1:0]   quotient_o
);
  import brs_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0]     dvd_q, dvd_d;
  logic [DIM_W-1:0]     rem_q, rem_d;
  logic [DIM_W-1:0]     dsr_q, dsr_d;

  // two restoring steps per cycle; quotient bits shift in behind the dividend
  always_comb begin
    logic [DIM_W:0]   r;
    logic [DIM_W-1:0] rm;
    logic [DVD_W-1:0] dv;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    rm     = rem_q;
    dv     = dvd_q;
    r      = '0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      for (int k = 0; k < 2; k++) begin
        r  = {rm, dv[DVD_W-1]};
        dv = {dv[DVD_W-2:0], 1'b0};
        if (r >= {1'b0, dsr_q}) begin
          r     = r - {1'b0, dsr_q};
          dv[0] = 1'b1;
        end
        rm = r[DIM_W-1:0];
      end
      dvd_d = dv;
      rem_d = rm;
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ----- sv/bilinear_gray_resampler.sv -----
// bilinear_gray_resampler: half-pixel-centred bilinear resize of an 8-bit image
// depends on brs_pkg and brs_div; holds the 256x256 image store
//
// A write beat (tuser low) stores one pixel. A sample beat (tuser high)
// passes a 9x9 multiply per axis, the two radix-4 dividers that form the
// source positions in parallel, four reads through the single read port
// of the image store and the blending steps, both rows on one shared
// multiplier and then the column. The result sits in an output register,
// so a new beat is taken while it waits. The store is not cleared after
// reset; pixels must be written before they are sampled. Size register
// values of 0 are used as 1 and values above 256 as 256.
module bilinear_gray_resampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // pos_x[7:0], pos_y[15:8], pixel_in[23:16]
  input  logic        s_axis_tuser,  // operation[0]
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // pixel_out[7:0]
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import brs_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_DSTART = 4'd2;
  localparam logic [3:0] S_DWAIT  = 4'd3;
  localparam logic [3:0] S_AXIS   = 4'd4;
  localparam logic [3:0] S_RD0    = 4'd5;
  localparam logic [3:0] S_RD1    = 4'd6;
  localparam logic [3:0] S_RD2    = 4'd7;
  localparam logic [3:0] S_RD3    = 4'd8;
  localparam logic [3:0] S_RD4    = 4'd9;
  localparam logic [3:0] S_TOP    = 4'd10;
  localparam logic [3:0] S_BOT    = 4'd11;
  localparam logic [3:0] S_VAL    = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(112);

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = v;
    return r;
  endfunction

  // clamp floor, neighbour and weight from the quotient less its half-pixel bias
  function automatic axis_t axis_clamp(input logic [DVD_W-1:0] q,
                                       input logic [DIM_W-1:0] s);
    logic [DVD_W-1:0]         pos;
    logic [DVD_W-FRAC_BITS-1:0] fl;
    logic [DIM_W-1:0]         smax;
    logic [DIM_W-1:0]         f1;
    logic [COORD_W-1:0]       f;
    axis_t                    a;
    pos  = q - HALF_POS;
    fl   = pos[DVD_W-1:FRAC_BITS];
    smax = s - DIM_W'(1);
    if (q < HALF_POS) begin
      f   = '0;
      a.w = '0;
    end else if (fl > (DVD_W-FRAC_BITS)'(smax)) begin
      f   = smax[COORD_W-1:0];
      a.w = W_ONE;
    end else begin
      f   = fl[COORD_W-1:0];
      a.w = {1'b0, pos[FRAC_BITS-1:0]};
    end
    f1   = {1'b0, f} + DIM_W'(1);
    a.i0 = f;
    a.i1 = (f1 < s) ? f1[COORD_W-1:0] : smax[COORD_W-1:0];
    return a;
  endfunction

  logic [DIM_W-1:0]   src_w_q, src_h_q, out_w_q, out_h_q;
  logic [3:0]         state_q, state_d;
  logic [COORD_W-1:0] ox_q, oy_q;
  logic [DIM_W-1:0]   sw_q, sh_q, dw_q, dh_q;
  logic [PROD_W-1:0]  px_q, py_q;
  logic [COORD_W-1:0] x0_q, x1_q, y0_q, y1_q;
  logic [W_W-1:0]     wx_q, wy_q;
  logic [PIX_W-1:0]   p00_q, p10_q, p01_q, p11_q;
  logic [23:0]        top_q, bot_q;
  logic [PIX_W-1:0]   res_q;
  logic               out_valid_q, out_valid_d;
  logic [PIX_W-1:0]   out_data_q;

  logic               in_beat, cfg_wr, mem_we, div_start;
  logic               done_x, done_y;
  logic [DVD_W-1:0]   q_x, q_y;
  logic [ADDR_W-1:0]  rd_addr;
  logic [PIX_W-1:0]   rd_data_q;
  logic [PIX_W-1:0]   mem [MAX_DIM*MAX_DIM];
  axis_t              ax, ay;

  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign mem_we    = in_beat && (s_axis_tuser == OP_WRITE);
  assign div_start = (state_q == S_DSTART);
  assign s_axis_tready = (state_q == S_IDLE);
  assign pready    = 1'b1;

  // register reads
  always_comb begin
    case (paddr[3:2])
      REG_SRC_W: prdata = 32'(src_w_q);
      REG_SRC_H: prdata = 32'(src_h_q);
      REG_OUT_W: prdata = 32'(out_w_q);
      REG_OUT_H: prdata = 32'(out_h_q);
      default:   prdata = '0;
    endcase
  end

  // size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= DIM_RESET;
      src_h_q <= DIM_RESET;
      out_w_q <= DIM_RESET;
      out_h_q <= DIM_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SRC_W: src_w_q <= pwdata[DIM_W-1:0];
        REG_SRC_H: src_h_q <= pwdata[DIM_W-1:0];
        REG_OUT_W: out_w_q <= pwdata[DIM_W-1:0];
        REG_OUT_H: out_h_q <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // position dividers, one per axis
  brs_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({px_q, (FRAC_BITS-1)'(0)}),
    .divisor_i  (dw_q),
    .done_o     (done_x),
    .quotient_o (q_x)
  );

  brs_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({py_q, (FRAC_BITS-1)'(0)}),
    .divisor_i  (dh_q),
    .done_o     (done_y),
    .quotient_o (q_y)
  );

  assign ax = axis_clamp(q_x, sw_q);
  assign ay = axis_clamp(q_y, sh_q);

  // neighbour address for each read slot
  always_comb begin
    case (state_q)
      S_RD0:   rd_addr = {y0_q, x0_q};
      S_RD1:   rd_addr = {y0_q, x1_q};
      S_RD2:   rd_addr = {y1_q, x0_q};
      default: rd_addr = {y1_q, x1_q};
    endcase
  end

  // image store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[{s_axis_tdata[15:8], s_axis_tdata[7:0]}] <= s_axis_tdata[23:16];
    rd_data_q <= mem[rd_addr];
  end

  // shared blend multiplier: rows in S_TOP and S_BOT
  logic [PIX_W-1:0]    bl_a, bl_b;
  logic signed [8:0]   row_diff;
  logic signed [26:0]  row_prod, row_sum;
  logic signed [24:0]  col_diff;
  logic signed [42:0]  col_prod, col_sum;

  always_comb begin
    bl_a     = (state_q == S_TOP) ? p00_q : p01_q;
    bl_b     = (state_q == S_TOP) ? p10_q : p11_q;
    row_diff = $signed({1'b0, bl_b}) - $signed({1'b0, bl_a});
    row_prod = row_diff * $signed({1'b0, wx_q});
    row_sum  = $signed({3'b0, bl_a, 16'b0}) + row_prod;
    col_diff = $signed({1'b0, bot_q}) - $signed({1'b0, top_q});
    col_prod = col_diff * $signed({1'b0, wy_q});
    col_sum  = $signed({3'b0, top_q, 16'b0}) + col_prod;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    case (state_q)
      S_IDLE:   if (in_beat && s_axis_tuser == OP_SAMPLE) state_d = S_MUL;
      S_MUL:    state_d = S_DSTART;
      S_DSTART: state_d = S_DWAIT;
      S_DWAIT:  if (done_x) state_d = S_AXIS;
      S_AXIS:   state_d = S_RD0;
      S_RD0:    state_d = S_RD1;
      S_RD1:    state_d = S_RD2;
      S_RD2:    state_d = S_RD3;
      S_RD3:    state_d = S_RD4;
      S_RD4:    state_d = S_TOP;
      S_TOP:    state_d = S_BOT;
      S_BOT:    state_d = S_VAL;
      S_VAL:    state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // sample datapath
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      ox_q <= s_axis_tdata[7:0];
      oy_q <= s_axis_tdata[15:8];
    end
    if (state_q == S_MUL) begin
      sw_q <= eff_dim(src_w_q);
      sh_q <= eff_dim(src_h_q);
      dw_q <= eff_dim(out_w_q);
      dh_q <= eff_dim(out_h_q);
      px_q <= PROD_W'({ox_q, 1'b1}) * PROD_W'(eff_dim(src_w_q));
      py_q <= PROD_W'({oy_q, 1'b1}) * PROD_W'(eff_dim(src_h_q));
    end
    if (state_q == S_AXIS) begin
      x0_q <= ax.i0;
      x1_q <= ax.i1;
      wx_q <= ax.w;
      y0_q <= ay.i0;
      y1_q <= ay.i1;
      wy_q <= ay.w;
    end
    if (state_q == S_RD1) p00_q <= rd_data_q;
    if (state_q == S_RD2) p10_q <= rd_data_q;
    if (state_q == S_RD3) p01_q <= rd_data_q;
    if (state_q == S_RD4) p11_q <= rd_data_q;
    if (state_q == S_TOP) top_q <= row_sum[23:0];
    if (state_q == S_BOT) bot_q <= row_sum[23:0];
    if (state_q == S_VAL) res_q <= col_sum[39:32];
    if (state_q == S_OUT && (!out_valid_q || m_axis_tready)) out_data_q <= res_q;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // both axis dividers run in lock step
  a_div_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_x == done_y)
    else $error("axis dividers out of step");

  // a result is only loaded from the final sequencer step
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_OUT))
    else $error("result raised outside the output step");

  // weights never exceed one once the axes are resolved
  a_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD0) |-> (wx_q <= W_ONE && wy_q <= W_ONE))
    else $error("weight above one");

  // the far neighbour is the near one or the next
  a_neigh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD0) |->
      ((x1_q == x0_q || {1'b0, x1_q} == {1'b0, x0_q} + 9'd1) &&
       (y1_q == y0_q || {1'b0, y1_q} == {1'b0, y0_q} + 9'd1)))
    else $error("neighbour index out of reach");

endmodule
